>>> hdl/ctb_pkg.sv
// Shared widths, limits, register indexes and beat types for the centerline band tracker.
package ctb_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 2048;

  localparam int unsigned COORD_W   = 11;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned HALF_W    = 13;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned X_CAP = ((MAX_WIDTH - 1) < 2047) ? (MAX_WIDTH - 1) : 2047;
  localparam int unsigned Y_CAP = ((MAX_HEIGHT - 1) < 2047) ? (MAX_HEIGHT - 1) : 2047;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;
  typedef logic [HALF_W-1:0]  half_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_BAND_WIDTH,
    CFG_MAX_BAND_WIDTH,
    CFG_MAX_CENTER_JUMP,
    CFG_MAX_GAP_ROWS,
    CFG_ROW_STEP,
    CFG_IMAGE_WIDTH,
    CFG_WINDOW_X,
    CFG_WINDOW_Y
  } cfg_reg_e;

  typedef struct packed {
    logic   on_target;
    coord_t column;
    coord_t pixel_row;
    logic   row_last;
    logic   frame_first;
  } pixel_t;

endpackage

>>> hdl/centerline_band_tracker_core.sv
// Top level of the centerline band tracker: run finder, band selection and row close.
//
//  channel | dir | handshake                | beat
//  --------+-----+--------------------------+-----------------------------------------------
//  in      | in  | in_valid_i / in_stall_o  | one pixel: on_target, column, row, row/frame marks
//  out     | out | out_valid_o / out_stall_i| one row result: found, point_x/y, tracking_lost
//  cfg     | in  | cfg_valid_i / cfg_ready_o| one register write: cfg_index_i, cfg_data_i
//
// One pixel per cycle while in_stall_o is low. A pixel is held in the input register, then the
// run/band logic updates the tracking state and, on a row_last pixel, loads the result register
// as that pixel leaves the input register.
// in_stall_o rises only while a row_last pixel waits on a full result register that is stalled;
// pixels that close no row never wait on the output side.
// Reset (rst_ni low, asynchronous) clears the pipeline and tracking state and loads the
// register reset values; the expected center starts at image_width half-pixels.
module centerline_band_tracker_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel beats
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            on_target_i,
  input  ctb_pkg::coord_t                 column_i,
  input  ctb_pkg::coord_t                 pixel_row_i,
  input  logic                            row_last_i,
  input  logic                            frame_first_i,
  // row result beats
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output ctb_pkg::coord_t                 point_x_o,
  output ctb_pkg::coord_t                 point_y_o,
  output logic                            tracking_lost_o,
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  ctb_pkg::cfg_word_t              cfg_data_i
);
  import ctb_pkg::*;

  // Configuration registers
  cfg_word_t min_band_width_q, max_band_width_q, max_center_jump_q, max_gap_rows_q;
  cfg_word_t row_step_q, image_width_q;
  coord_t    window_x_q, window_y_q;

  // Input register
  logic   s1_valid_q;
  pixel_t s1_q;
  logic   advance;

  // Tracking state
  logic      in_run_q, in_run_n;
  coord_t    run_start_q, run_start_n;
  logic      best_valid_q, best_valid_n;
  coord_t    best_left_q, best_left_n;
  coord_t    best_right_q, best_right_n;
  half_t     best_dist_q, best_dist_n;
  half_t     exp_center_q, exp_center_n;
  logic      have_points_q, have_points_n;
  cfg_word_t gap_count_q, gap_count_n;
  logic      stopped_q, stopped_n;

  // State as seen after a frame start clears it
  logic      in_run_e, best_valid_e, have_points_e, stopped_e;
  half_t     exp_center_e;
  cfg_word_t gap_count_e;

  // Run candidate
  logic      cons_en;
  coord_t    cons_l, cons_r;
  logic      order_ok, width_ok, jump_ok, closer, take;
  cfg_word_t run_width;
  cfg_word_t run_sum;
  half_t     run_sum_h, run_dist;

  // Row close
  logic      best_valid_a;
  coord_t    best_left_a, best_right_a;
  half_t     best_dist_a;
  cfg_word_t mid_sum;
  coord_t    cx;
  cfg_word_t px_raw, py_raw;
  logic [CFG_W:0] gap_sum;
  cfg_word_t gap_sat;
  logic      res_found, res_lost;
  coord_t    res_x, res_y;

  // Result register
  logic   out_valid_q;
  logic   found_q, lost_q;
  coord_t point_x_q, point_y_q;

  // ---------------------------------------------------------------------------------------------
  // Config: writes taken at any time; the user, not the block, keeps it idle when they come.
  // ---------------------------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_band_width_q  <= CFG_W'(1);
      max_band_width_q  <= CFG_W'(2048);
      max_center_jump_q <= CFG_W'(2048);
      max_gap_rows_q    <= CFG_W'(2048);
      row_step_q        <= CFG_W'(1);
      image_width_q     <= CFG_W'(2048);
      window_x_q        <= '0;
      window_y_q        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_MIN_BAND_WIDTH:  min_band_width_q  <= cfg_data_i;
        CFG_MAX_BAND_WIDTH:  max_band_width_q  <= cfg_data_i;
        CFG_MAX_CENTER_JUMP: max_center_jump_q <= cfg_data_i;
        CFG_MAX_GAP_ROWS:    max_gap_rows_q    <= cfg_data_i;
        CFG_ROW_STEP:        row_step_q        <= cfg_data_i;
        CFG_IMAGE_WIDTH:     image_width_q     <= cfg_data_i;
        CFG_WINDOW_X:        window_x_q        <= cfg_data_i[COORD_W-1:0];
        CFG_WINDOW_Y:        window_y_q        <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Flow control: a pixel leaves the input register unless it closes a row while the result
  // register is full and stalled.
  // ---------------------------------------------------------------------------------------------
  assign advance    = s1_valid_q && (!s1_q.row_last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_q <= '{on_target:   on_target_i,
                column:      column_i,
                pixel_row:   pixel_row_i,
                row_last:    row_last_i,
                frame_first: frame_first_i};
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Frame start clears tracking before the pixel itself is handled.
  // ---------------------------------------------------------------------------------------------
  assign in_run_e      = s1_q.frame_first ? 1'b0 : in_run_q;
  assign best_valid_e  = s1_q.frame_first ? 1'b0 : best_valid_q;
  assign have_points_e = s1_q.frame_first ? 1'b0 : have_points_q;
  assign stopped_e     = s1_q.frame_first ? 1'b0 : stopped_q;
  assign gap_count_e   = s1_q.frame_first ? '0 : gap_count_q;
  assign exp_center_e  = s1_q.frame_first ? {1'b0, image_width_q} : exp_center_q;

  // Run tracking: open on the first on-pixel, close on an off-pixel (ending one column back)
  // or on the row's last pixel (ending at it).
  always_comb begin
    in_run_n    = in_run_e;
    run_start_n = run_start_q;
    cons_en     = 1'b0;
    cons_l      = run_start_q;
    cons_r      = s1_q.column;
    if (!stopped_e) begin
      if (s1_q.on_target) begin
        if (!in_run_e) begin
          in_run_n    = 1'b1;
          run_start_n = s1_q.column;
        end
        if (s1_q.row_last) begin
          cons_en  = 1'b1;
          cons_l   = in_run_e ? run_start_q : s1_q.column;
          in_run_n = 1'b0;
        end
      end else if (in_run_e) begin
        cons_en  = s1_q.column > run_start_q;
        cons_r   = s1_q.column - COORD_W'(1);
        in_run_n = 1'b0;
      end
    end
  end

  // Candidate check: width within the band, center within the jump limit once a point exists,
  // and strictly closer than the best so far (earliest run wins ties).
  assign order_ok  = cons_r >= cons_l;
  assign run_width = {1'b0, cons_r} - {1'b0, cons_l} + CFG_W'(1);
  assign width_ok  = (run_width >= min_band_width_q) && (run_width <= max_band_width_q);
  assign run_sum   = {1'b0, cons_l} + {1'b0, cons_r};
  assign run_sum_h = {1'b0, run_sum};
  assign run_dist  = (run_sum_h >= exp_center_e) ? (run_sum_h - exp_center_e)
                                                 : (exp_center_e - run_sum_h);
  assign jump_ok   = !have_points_e || (run_dist <= {max_center_jump_q, 1'b0});
  assign closer    = !best_valid_e || (run_dist < best_dist_q);
  assign take      = cons_en && order_ok && width_ok && jump_ok && closer;

  assign best_valid_a = best_valid_e || take;
  assign best_left_a  = take ? cons_l   : best_left_q;
  assign best_right_a = take ? cons_r   : best_right_q;
  assign best_dist_a  = take ? run_dist : best_dist_q;

  // Row close arithmetic: midpoint, window offsets with saturation, gap count with saturation.
  assign mid_sum = {1'b0, best_left_a} + {1'b0, best_right_a};
  assign cx      = mid_sum[CFG_W-1:1];
  assign px_raw  = {1'b0, cx} + {1'b0, window_x_q};
  assign py_raw  = {1'b0, s1_q.pixel_row} + {1'b0, window_y_q};
  assign gap_sum = {1'b0, gap_count_e} + {1'b0, row_step_q};
  assign gap_sat = gap_sum[CFG_W] ? {CFG_W{1'b1}} : gap_sum[CFG_W-1:0];

  always_comb begin
    best_valid_n  = best_valid_a;
    best_left_n   = best_left_a;
    best_right_n  = best_right_a;
    best_dist_n   = best_dist_a;
    exp_center_n  = exp_center_e;
    have_points_n = have_points_e;
    gap_count_n   = gap_count_e;
    stopped_n     = stopped_e;
    res_found     = 1'b0;
    res_x         = '0;
    res_y         = '0;
    if (s1_q.row_last) begin
      if (!stopped_e) begin
        if (best_valid_a) begin
          res_found     = 1'b1;
          res_x         = (px_raw > CFG_W'(X_CAP)) ? COORD_W'(X_CAP) : px_raw[COORD_W-1:0];
          res_y         = (py_raw > CFG_W'(Y_CAP)) ? COORD_W'(Y_CAP) : py_raw[COORD_W-1:0];
          exp_center_n  = {1'b0, cx, 1'b0};
          have_points_n = 1'b1;
          gap_count_n   = '0;
        end else if (have_points_e) begin
          gap_count_n = gap_sat;
          stopped_n   = gap_sat > max_gap_rows_q;
        end
      end
      best_valid_n = 1'b0;
    end
  end

  assign res_lost = stopped_n;

  // ---------------------------------------------------------------------------------------------
  // Advance tracking state once per pixel that leaves the input register.
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q      <= 1'b0;
      best_valid_q  <= 1'b0;
      exp_center_q  <= HALF_W'(2048);
      have_points_q <= 1'b0;
      gap_count_q   <= '0;
      stopped_q     <= 1'b0;
    end else if (advance) begin
      in_run_q      <= s1_q.row_last ? 1'b0 : in_run_n;
      best_valid_q  <= best_valid_n;
      exp_center_q  <= exp_center_n;
      have_points_q <= have_points_n;
      gap_count_q   <= gap_count_n;
      stopped_q     <= stopped_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      run_start_q  <= run_start_n;
      best_left_q  <= best_left_n;
      best_right_q <= best_right_n;
      best_dist_q  <= best_dist_n;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result register: load on a closing pixel, hold while stalled, drop once taken.
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s1_q.row_last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_q.row_last) begin
      found_q   <= res_found;
      point_x_q <= res_x;
      point_y_q <= res_y;
      lost_q    <= res_lost;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign point_x_o       = point_x_q;
  assign point_y_o       = point_y_q;
  assign tracking_lost_o = lost_q;

endmodule

>>> hdl/ctb_checker.sv
// Port-level checks for the centerline band tracker and their bind to the top level.
module ctb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          found_o,
  input ctb_pkg::coord_t               point_x_o,
  input ctb_pkg::coord_t               point_y_o,
  input logic                          tracking_lost_o
);
  import ctb_pkg::*;

  // A found point resets the gap, so it never comes with tracking lost.
  a_found_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> !tracking_lost_o)
    else $error("found point reported with tracking lost");

  // Rows without a point report zero coordinates.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (point_x_o == '0 && point_y_o == '0))
    else $error("row without a point has nonzero coordinates");

  // Coordinates stay within the saturation caps.
  a_caps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (point_x_o <= COORD_W'(X_CAP) && point_y_o <= COORD_W'(Y_CAP)))
    else $error("point beyond saturation cap");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(found_o) && $stable(point_x_o) && $stable(point_y_o)
       && $stable(tracking_lost_o)))
    else $error("stalled result beat changed");

endmodule

bind centerline_band_tracker_core ctb_checker u_ctb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .found_o         (found_o),
  .point_x_o       (point_x_o),
  .point_y_o       (point_y_o),
  .tracking_lost_o (tracking_lost_o)
);
